// ===== rtl/core/trapi_pkg.sv =====
// ============================================================================
// trapi_pkg: shared types and constants of the trapezoid integral table
// Opcodes, register indexes, reset values and the request and response
// payload structures used by the integral table and its testbench.
// ============================================================================
package trapi_pkg;

   localparam int VALUE_W     = 48;
   localparam int SAMPLE_W    = 32;
   localparam int INDEX_W     = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_NEXT  = 2'd1,
      OP_QUERY = 2'd2,
      OP_SPARE = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INITIAL_VALUE  = 3'd0,
      CSR_RANGE_START    = 3'd1,
      CSR_RANGE_END      = 3'd2,
      CSR_SAMPLE_STEP    = 3'd3,
      CSR_POSITION_SCALE = 3'd4,
      CSR_SAMPLE_COUNT   = 3'd5
   } csr_index_type;

   localparam logic signed [VALUE_W-1:0]  INITIAL_VALUE_RST  = 48'sd0;
   localparam logic signed [SAMPLE_W-1:0] RANGE_START_RST    = 32'sd0;
   localparam logic signed [SAMPLE_W-1:0] RANGE_END_RST      = 32'sd65536;
   localparam logic [30:0]                SAMPLE_STEP_RST    = 31'd33;
   localparam logic [31:0]                POSITION_SCALE_RST = 32'd131006464;
   localparam logic [11:0]                SAMPLE_COUNT_RST   = 12'd2000;

   typedef struct packed {
      opcode_type                  opcode;
      logic signed [SAMPLE_W-1:0]  sample_value;
      logic signed [SAMPLE_W-1:0]  query_x;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   result_value;
      logic [INDEX_W-1:0]          table_index;
      logic                        out_of_range;
   } rsp_type;

endpackage

// ===== rtl/core/trapi_table_ram.sv =====
// ============================================================================
// trapi_table_ram: integral table storage
// Simple dual-port memory, one write and one read port, registered read data.
// ============================================================================
module trapi_table_ram #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/trapezoid_integral_table_interp.sv =====
// ============================================================================
// trapezoid_integral_table_interp: cumulative trapezoid integral table
// Builds a table of running integrals from uniformly spaced samples and
// answers queries by linear interpolation between neighboring entries.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_type (opcode, sample, x)
//   rsp_      out        rsp_valid / rsp_ready   rsp_type (value, index, flag)
//   csr_      in         csr_write               csr_index, csr_wdata
//
// An item is taken in the idle state and then runs one step per cycle:
// start, unused opcode and rejected items end in the execute step; a load
// runs product, then accumulate and table write; a query runs product, two
// reads through the single table read port, difference, blend multiply,
// final add. A finished result moves into the output register; the item
// stalls in its last step only while that register still holds an untaken
// result. Reset is synchronous and clears control and integrator state; the
// table itself is not cleared and is valid only where it has been loaded.
// ============================================================================
module trapezoid_integral_table_interp
   import trapi_pkg::*;
#(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LACC,
      ST_QADDR,
      ST_QRDB,
      ST_QDIFF,
      ST_QMIX,
      ST_QSUM
   } state_type;

   // Configuration registers.
   logic signed [VALUE_W-1:0]  initial_value_ff;
   logic signed [SAMPLE_W-1:0] range_start_ff;
   logic signed [SAMPLE_W-1:0] range_end_ff;
   logic [30:0]                sample_step_ff;
   logic [31:0]                position_scale_ff;
   logic [11:0]                sample_count_ff;

   // Integrator state.
   logic signed [VALUE_W-1:0]  running_ff;
   logic signed [SAMPLE_W-1:0] previous_ff;
   logic [ADDR_W-1:0]          load_pos_ff;

   // Control and output register.
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   // Per-item datapath registers.
   req_type                    item_ff;
   logic signed [63:0]         product_ff;
   logic [63:0]                pos_ff;
   logic [ADDR_W-1:0]          sel_index_ff;
   logic [15:0]                frac_ff;
   logic                       past_end_ff;
   logic signed [VALUE_W-1:0]  entry_a_ff;
   logic signed [VALUE_W:0]    diff_ff;
   logic signed [65:0]         mix_ff;

   logic [ADDR_W-1:0]          last_index;
   logic                       slot_free;
   logic                       finish;
   logic                       fire;
   rsp_type                    finish_data;
   logic                       table_full;
   logic                       query_outside;
   logic [ADDR_W-1:0]          next_pos;

   logic signed [31:0]         step_s;
   logic signed [32:0]         sample_sum;
   logic signed [64:0]         load_product;
   logic signed [63:0]         load_shift;
   logic signed [VALUE_W:0]    acc_wide;
   logic signed [VALUE_W-1:0]  acc_sat;

   logic signed [32:0]         query_delta;
   logic [63:0]                query_product;
   logic [31:0]                pos_int;
   logic                       past_end_now;

   logic signed [16:0]         frac_s;
   logic signed [65:0]         mix_product;
   logic signed [65:0]         mix_shift;
   logic signed [VALUE_W-1:0]  interp_value;

   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic signed [VALUE_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]          mem_raddr;
   logic signed [VALUE_W-1:0]  mem_rdata;

   // ---------------------------------------------------------------- table
   trapi_table_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_value_ff  <= INITIAL_VALUE_RST;
         range_start_ff    <= RANGE_START_RST;
         range_end_ff      <= RANGE_END_RST;
         sample_step_ff    <= SAMPLE_STEP_RST;
         position_scale_ff <= POSITION_SCALE_RST;
         sample_count_ff   <= SAMPLE_COUNT_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INITIAL_VALUE:  initial_value_ff  <= csr_wdata;
            CSR_RANGE_START:    range_start_ff    <= csr_wdata[31:0];
            CSR_RANGE_END:      range_end_ff      <= csr_wdata[31:0];
            CSR_SAMPLE_STEP:    sample_step_ff    <= csr_wdata[30:0];
            CSR_POSITION_SCALE: position_scale_ff <= csr_wdata[31:0];
            CSR_SAMPLE_COUNT:   sample_count_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // The count in use is clamped to [1, TABLE_DEPTH]; last_index is count-1.
   always_comb begin
      if (sample_count_ff == 12'd0) begin
         last_index = '0;
      end else if (32'(sample_count_ff) > TABLE_DEPTH) begin
         last_index = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         last_index = ADDR_W'(sample_count_ff - 12'd1);
      end
   end

   // ------------------------------------------------------------ load math
   assign step_s       = $signed({1'b0, sample_step_ff});
   assign sample_sum   = 33'(previous_ff) + 33'(item_ff.sample_value);
   assign load_product = step_s * sample_sum;

   // Halving and the move to Q32.16 are one arithmetic shift by 17.
   assign load_shift = product_ff >>> 17;
   assign acc_wide   = 49'(running_ff) + $signed(load_shift[VALUE_W:0]);

   always_comb begin
      if (acc_wide[VALUE_W] != acc_wide[VALUE_W-1]) begin
         acc_sat = acc_wide[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                     : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         acc_sat = acc_wide[VALUE_W-1:0];
      end
   end

   assign table_full = (load_pos_ff >= last_index);
   assign next_pos   = load_pos_ff + ADDR_W'(1);

   // ----------------------------------------------------------- query math
   assign query_outside = (item_ff.query_x < range_start_ff) ||
                          (item_ff.query_x > range_end_ff);
   assign query_delta   = 33'(item_ff.query_x) - 33'(range_start_ff);
   assign query_product = query_delta[31:0] * position_scale_ff;

   assign pos_int      = pos_ff[63:32];
   assign past_end_now = (pos_int >= 32'(last_index));

   // T[i]*(1-f) + T[i+1]*f is evaluated as T[i] + (T[i+1]-T[i])*f.
   assign frac_s       = $signed({1'b0, frac_ff});
   assign mix_product  = diff_ff * frac_s;
   assign mix_shift    = mix_ff >>> 16;
   assign interp_value = entry_a_ff + $signed(mix_shift[VALUE_W-1:0]);

   always_comb begin
      case (state_ff)
         ST_QADDR: mem_raddr = past_end_now ? last_index : ADDR_W'(pos_int);
         ST_QRDB:  mem_raddr = past_end_ff ? sel_index_ff : sel_index_ff + ADDR_W'(1);
         default:  mem_raddr = sel_index_ff;
      endcase
   end

   // ------------------------------------------------------------ sequencer
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      finish      = 1'b0;
      finish_data = '0;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (item_ff.opcode)
               OP_START: begin
                  finish                   = 1'b1;
                  finish_data.result_value = initial_value_ff;
               end
               OP_NEXT: begin
                  if (table_full) begin
                     // A full table rejects the sample and reports its state.
                     finish                   = 1'b1;
                     finish_data.result_value = running_ff;
                     finish_data.table_index  = INDEX_W'(load_pos_ff);
                     finish_data.out_of_range = 1'b1;
                  end else begin
                     state_in = ST_LACC;
                  end
               end
               OP_QUERY: begin
                  if (query_outside) begin
                     finish                   = 1'b1;
                     finish_data.out_of_range = 1'b1;
                  end else begin
                     state_in = ST_QADDR;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_LACC: begin
            finish                   = 1'b1;
            finish_data.result_value = acc_sat;
            finish_data.table_index  = INDEX_W'(next_pos);
         end
         ST_QADDR: state_in = ST_QRDB;
         ST_QRDB:  state_in = ST_QDIFF;
         ST_QDIFF: state_in = ST_QMIX;
         ST_QMIX:  state_in = ST_QSUM;
         ST_QSUM: begin
            finish                   = 1'b1;
            finish_data.result_value = interp_value;
            finish_data.table_index  = INDEX_W'(sel_index_ff);
         end
         default: state_in = ST_IDLE;
      endcase

      fire         = finish && slot_free;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = finish_data;
         state_in     = ST_IDLE;
      end
   end

   // Table writes happen only when the item's result transfers into the
   // output register, so a stalled load never writes twice.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = next_pos;
      mem_wdata = acc_sat;
      if (fire && state_ff == ST_EXEC && item_ff.opcode == OP_START) begin
         mem_we    = 1'b1;
         mem_waddr = '0;
         mem_wdata = initial_value_ff;
      end else if (fire && state_ff == ST_LACC) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= '0;
         previous_ff <= '0;
         load_pos_ff <= '0;
      end else if (fire && state_ff == ST_EXEC && item_ff.opcode == OP_START) begin
         running_ff  <= initial_value_ff;
         previous_ff <= item_ff.sample_value;
         load_pos_ff <= '0;
      end else if (fire && state_ff == ST_LACC) begin
         running_ff  <= acc_sat;
         previous_ff <= item_ff.sample_value;
         load_pos_ff <= next_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_EXEC) begin
         product_ff <= load_product[63:0];
         pos_ff     <= query_product;
      end
      if (state_ff == ST_QADDR) begin
         past_end_ff  <= past_end_now;
         sel_index_ff <= past_end_now ? last_index : ADDR_W'(pos_int);
         frac_ff      <= past_end_now ? 16'd0 : pos_ff[31:16];
      end
      if (state_ff == ST_QRDB) begin
         entry_a_ff <= mem_rdata;
      end
      if (state_ff == ST_QDIFF) begin
         diff_ff <= 49'(mem_rdata) - 49'(entry_a_ff);
      end
      if (state_ff == ST_QMIX) begin
         mix_ff <= mix_product;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < TABLE_DEPTH))
      else $error("table write outside the table depth");

   a_blend_follows_multiply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QSUM) |-> ($past(state_ff) == ST_QMIX || $past(state_ff) == ST_QSUM))
      else $error("query result formed without a fresh blend product");
`endif

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb: testbench of the trapezoid integral table with interpolated read-back
// Builds integral tables from streamed samples and queries them under random
// handshake gaps and stalls. A predictor computes every result as each item
// is transferred, and a checker compares the responses field by field.
// ============================================================================
module tb;
   import trapi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     TABLE_DEPTH = 2048;
   localparam int     QUIET_LIMIT = 2000;
   localparam longint ACC_MAX     = (64'sd1 <<< 47) - 64'sd1;
   localparam longint ACC_MIN     = -(64'sd1 <<< 47);

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Configuration as the block holds it.
   logic signed [47:0] cfg_initial;
   logic signed [31:0] cfg_range_start;
   logic signed [31:0] cfg_range_end;
   logic [30:0]        cfg_step;
   logic [31:0]        cfg_scale;
   logic [11:0]        cfg_count;

   // Integrator state mirrored from the transfers seen so far.
   logic signed [47:0] integral_table [TABLE_DEPTH];
   bit                 loaded [TABLE_DEPTH];
   logic signed [47:0] running_sum;
   logic signed [31:0] prev_sample;
   int unsigned        fill_pos;

   rsp_type integral_answers [$];
   int      failures     = 0;
   int      result_count = 0;
   int      quiet_cycles = 0;
   int      ready_hold   = 0;
   bit      full_rate    = 1'b0;

   trapezoid_integral_table_interp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 48);
   endfunction

   function automatic int unsigned last_entry();
      int unsigned c;
      c = cfg_count;
      if (c > TABLE_DEPTH) c = TABLE_DEPTH;
      if (c < 1) c = 1;
      return c - 1;
   endfunction

   function automatic void reset_predictor();
      cfg_initial     = INITIAL_VALUE_RST;
      cfg_range_start = RANGE_START_RST;
      cfg_range_end   = RANGE_END_RST;
      cfg_step        = SAMPLE_STEP_RST;
      cfg_scale       = POSITION_SCALE_RST;
      cfg_count       = SAMPLE_COUNT_RST;
      foreach (loaded[i]) begin
         loaded[i] = 1'b0;
         integral_table[i] = '0;
      end
      running_sum = '0;
      prev_sample = '0;
      fill_pos    = 0;
   endfunction

   // Integer part of the table position is the lower neighbor; the next
   // sixteen bits are the blend weight of the upper one.
   function automatic void map_position(input logic signed [31:0] x,
                                        output logic [31:0] ia,
                                        output int unsigned frac);
      logic [63:0] offs;
      logic [63:0] pos;
      offs = 64'(longint'(x) - longint'(cfg_range_start));
      pos  = offs * {32'b0, cfg_scale};
      ia   = pos[63:32];
      frac = pos[31:16];
   endfunction

   function automatic bit query_is_safe(input logic signed [31:0] x);
      logic [31:0] ia;
      int unsigned frac;
      if (x < cfg_range_start || x > cfg_range_end) return 1'b1;
      map_position(x, ia, frac);
      if (ia >= last_entry()) return loaded[last_entry()];
      return loaded[ia] && loaded[ia + 1];
   endfunction

   function automatic rsp_type advance_integrator(input req_type item);
      rsp_type     r;
      int unsigned last;
      longint      acc;
      longint      mix;
      logic [31:0] ia;
      int unsigned frac;
      r    = '0;
      last = last_entry();
      case (item.opcode)
         OP_START: begin
            integral_table[0] = cfg_initial;
            loaded[0]         = 1'b1;
            running_sum       = cfg_initial;
            prev_sample       = item.sample_value;
            fill_pos          = 0;
            r.result_value    = cfg_initial;
         end
         OP_NEXT: begin
            if (fill_pos >= last) begin
               // The table is full: nothing moves and the flag marks the refusal.
               r.result_value = running_sum;
               r.table_index  = fill_pos[10:0];
               r.out_of_range = 1'b1;
            end else begin
               acc = (longint'(cfg_step) *
                      (longint'(prev_sample) + longint'(item.sample_value))) >>> 17;
               acc = acc + longint'(running_sum);
               if (acc > ACC_MAX) acc = ACC_MAX;
               else if (acc < ACC_MIN) acc = ACC_MIN;
               running_sum = acc[47:0];
               prev_sample = item.sample_value;
               fill_pos++;
               integral_table[fill_pos] = running_sum;
               loaded[fill_pos]         = 1'b1;
               r.result_value = running_sum;
               r.table_index  = fill_pos[10:0];
            end
         end
         OP_QUERY: begin
            if (item.query_x < cfg_range_start || item.query_x > cfg_range_end) begin
               r.out_of_range = 1'b1;
            end else begin
               map_position(item.query_x, ia, frac);
               if (ia >= last) begin
                  r.result_value = integral_table[last];
                  r.table_index  = last[10:0];
               end else begin
                  mix = longint'(integral_table[ia]) * longint'(65536 - frac)
                      + longint'(integral_table[ia + 1]) * longint'(frac);
                  r.result_value = mix[63:16];
                  r.table_index  = ia[10:0];
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type pack_req(input opcode_type op, input logic [31:0] s,
                                        input logic [31:0] x);
      req_type item;
      item.opcode       = op;
      item.sample_value = s;
      item.query_x      = x;
      return item;
   endfunction

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 7))
         4: return $urandom_range(0, 131071) - 65536;
         5: return 32'h7FFF_FFFF;
         6: return 32'h8000_0000;
         7: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_query_x();
      logic [63:0] d;
      longint      target;
      int unsigned j;
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return cfg_range_start;
         2: return cfg_range_end;
         3: return cfg_range_start - 1;
         4: return cfg_range_end + 1;
         default: begin
            // Aim at an entry of the current fill.
            j = $urandom_range(0, fill_pos);
            if (cfg_scale == 0) d = $urandom;
            else d = ((64'(j) << 32) + 64'($urandom)) / {32'b0, cfg_scale};
            if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
            target = longint'(cfg_range_start) + longint'(d);
            if (target > 64'sd2147483647) return cfg_range_end;
            return target[31:0];
         end
      endcase
   endfunction

   // Queries never touch an entry that has not been loaded since reset.
   function automatic req_type make_query();
      logic signed [31:0] x;
      int                 tries;
      for (tries = 0; tries < 8; tries++) begin
         x = pick_query_x();
         if (query_is_safe(x)) return pack_req(OP_QUERY, $urandom, x);
      end
      if (cfg_range_start != 32'sh8000_0000)
         return pack_req(OP_QUERY, $urandom, cfg_range_start - 1);
      if (cfg_range_end != 32'sh7FFF_FFFF)
         return pack_req(OP_QUERY, $urandom, cfg_range_end + 1);
      return pack_req(OP_SPARE, $urandom, $urandom);
   endfunction

   // Valid is only lowered ahead of a gap, so back-to-back transfers keep it high.
   task automatic send_item(input req_type item);
      int gap;
      gap = full_rate ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      integral_answers.push_back(advance_integrator(item));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (integral_answers.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [47:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Bits above a register's width carry noise; the block must ignore them.
   task automatic apply_settings(input logic [47:0] init, input logic [31:0] rstart,
                                 input logic [31:0] rend, input logic [30:0] step,
                                 input logic [31:0] scale, input logic [11:0] count);
      write_csr(CSR_INITIAL_VALUE, init);
      write_csr(CSR_RANGE_START, {16'($urandom), rstart});
      write_csr(CSR_RANGE_END, {16'($urandom), rend});
      write_csr(CSR_SAMPLE_STEP, {17'($urandom), step});
      write_csr(CSR_POSITION_SCALE, {16'($urandom), scale});
      write_csr(CSR_SAMPLE_COUNT, {$urandom, 4'($urandom), count});
      csr_write <= 1'b0;
      cfg_initial     = init;
      cfg_range_start = rstart;
      cfg_range_end   = rend;
      cfg_step        = step;
      cfg_scale       = scale;
      cfg_count       = count;
   endtask

   task automatic test_reset_state();
      send_item(pack_req(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h8000_0000));
      send_item(pack_req(OP_QUERY, 32'h0, 32'd65537));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h7FFF_FFFF));
      // A load ahead of any start accumulates from the cleared integrator.
      send_item(pack_req(OP_NEXT, 32'h7FFF_FFFF, 32'h0));
      send_item(pack_req(OP_START, 32'h8000_0000, 32'h0));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h0, 32'hFFFF_FFFF));
   endtask

   task automatic test_saturation_extremes();
      wait_idle();
      apply_settings(48'h7FFF_FFFF_FFFF, 32'hFFFF_0000, 32'h0001_0000,
                     31'h7FFF_FFFF, 32'd98304, 12'd4);
      send_item(pack_req(OP_START, 32'h7FFF_FFFF, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h7FFF_FFFF, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h8000_0000, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h8000_0000, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h1234_5678, 32'h0));
      send_item(pack_req(OP_QUERY, 32'h0, 32'hFFFF_0000));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h0001_0000));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h0001_0001));
      send_item(pack_req(OP_QUERY, 32'h0, 32'hFFFE_FFFF));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h0));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h0000_5555));

      // Full x range, largest scale: every x from two above the range start on lands past the end.
      wait_idle();
      apply_settings(48'h8000_0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     31'h7FFF_FFFF, 32'hFFFF_FFFF, 12'd2);
      send_item(pack_req(OP_START, 32'h8000_0000, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h8000_0000, 32'h0));
      send_item(pack_req(OP_NEXT, 32'h8000_0000, 32'h0));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h8000_0000));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h8000_0001));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h7FFF_FFFF));
   endtask

   task automatic test_inverted_range();
      wait_idle();
      apply_settings(48'd12345, 32'd100, 32'hFFFF_FF9C, 31'd1, 32'd0, 12'd2048);
      send_item(pack_req(OP_START, 32'd65536, 32'h0));
      send_item(pack_req(OP_QUERY, 32'h0, 32'h0));
      send_item(pack_req(OP_QUERY, 32'h0, 32'd100));
   endtask

   task automatic test_random_fills();
      int          phase;
      int          sent;
      int          quota;
      int          pick;
      bit          big;
      logic [47:0] init;
      logic [31:0] rstart;
      logic [31:0] rend;
      logic [30:0] step;
      logic [31:0] scale;
      logic [11:0] count;
      logic [63:0] span;
      logic [63:0] ratio;
      longint      top;
      for (phase = 0; phase < 8; phase++) begin
         big   = (phase == 3);
         count = big ? 12'd2048 : 12'($urandom_range(0, 3) == 0 ?
                                     $urandom_range(41, 300) : $urandom_range(2, 40));
         case ($urandom_range(0, 3))
            0: begin
               init[47:32] = $urandom;
               init[31:0]  = $urandom;
            end
            1: init = 48'h7FFF_FFFF_FFFF;
            2: init = 48'h8000_0000_0000;
            default: init = $urandom_range(0, 2097151) - 1048576;
         endcase
         case ($urandom_range(0, 3))
            0: step = $urandom;
            1: step = 31'h7FFF_FFFF;
            default: step = $urandom_range(1, 65536);
         endcase
         rstart = $urandom;
         case ($urandom_range(0, 3))
            0: span = $urandom_range(1, 1 << 20);
            1: span = $urandom;
            2: span = 64'(count) << 16;
            default: span = $urandom_range(65536, 1 << 24);
         endcase
         if (span == 0) span = 1;
         top = longint'($signed(rstart)) + longint'(span);
         rend = (top > 64'sd2147483647) ? 32'h7FFF_FFFF : top[31:0];
         ratio = ((64'(count) - 64'd1) << 32) / span;
         scale = (ratio > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ratio[31:0];
         case ($urandom_range(0, 11))
            0: scale = 32'd0;
            1: scale = 32'hFFFF_FFFF;
            2: scale = $urandom;
            3: begin
               // Inverted range: every query is refused.
               rstart = rend;
               rend   = rstart - $urandom_range(1, 1 << 20);
            end
            default: ;
         endcase
         wait_idle();
         apply_settings(init, rstart, rend, step, scale, count);
         quota = big ? 400 : 180;
         send_item(pack_req(OP_START, rand_sample(), $urandom));
         for (sent = 1; sent < quota; sent++) begin
            if (sent % 50 == 0) full_rate = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 4 || (big && pick < 8))
               send_item(pack_req(OP_SPARE, $urandom, $urandom));
            else if (pick < 8 || (fill_pos >= last_entry() && $urandom_range(0, 3) != 0))
               send_item(pack_req(OP_START, rand_sample(), $urandom));
            else if (pick < 32)
               send_item(make_query());
            else
               send_item(pack_req(OP_NEXT, rand_sample(), $urandom));
         end
         full_rate = 1'b0;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (integral_answers.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("result %0d: transfer with nothing pending (value %0d index %0d flag %0b)",
                           result_count, rsp_data.result_value, rsp_data.table_index,
                           rsp_data.out_of_range);
            end else begin
               want = integral_answers.pop_front();
               if (rsp_data.result_value !== want.result_value ||
                   rsp_data.table_index !== want.table_index ||
                   rsp_data.out_of_range !== want.out_of_range) begin
                  failures++;
                  if (failures <= 10)
                     $display("result %0d: expected value %0d index %0d flag %0b, got value %0d index %0d flag %0b",
                              result_count, want.result_value, want.table_index,
                              want.out_of_range, rsp_data.result_value,
                              rsp_data.table_index, rsp_data.out_of_range);
               end
            end
         end
         if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            rsp_ready  <= 1'b0;
         end else if (!full_rate && $urandom_range(0, 4) == 0) begin
            ready_hold <= pick_gap();
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("[trapezoid_integral_table_interp] ERROR");
         $finish;
      end
   end

   initial begin
      reset_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_saturation_extremes();
      test_inverted_range();
      test_random_fills();
      wait_idle();
      if (failures == 0 && integral_answers.size() == 0)
         $display("[trapezoid_integral_table_interp] OK");
      else
         $display("[trapezoid_integral_table_interp] ERROR");
      $finish;
   end

endmodule
